@@ src/aes_pkg.sv @@
// aes_pkg: shared types, constants, s-box functions for the aes-256 block cipher
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package aes_pkg;

	localparam int unsigned SCHED_WORDS = 60;
	localparam int unsigned ROUNDS      = 14;

	typedef enum logic [1:0] {
		REG_KEY0 = 2'd0,
		REG_KEY1 = 2'd1,
		REG_KEY2 = 2'd2,
		REG_KEY3 = 2'd3
	} reg_idx_t;

	typedef enum logic {
		CMD_ENCRYPT = 1'b0,
		CMD_DECRYPT = 1'b1
	} cmd_t;

	typedef struct packed {
		logic        command;
		logic [63:0] block_upper;
		logic [63:0] block_lower;
	} in_item_t;

	typedef struct packed {
		logic [63:0] result_upper;
		logic [63:0] result_lower;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXPAND,
		ST_PRIME,
		ST_WHITEN,
		ST_ROUND,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic       load;      // capture input block
		logic       exp_start; // begin key expansion
		logic       exp_step;  // expand one schedule word
		logic       addk;      // initial key addition
		logic       round;     // apply one round to the state
		logic [3:0] rnd;       // round index being applied
		logic       fetch;     // read key for the next step
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic       exp_done;
	} dp_status_t;

	function automatic logic [7:0] xt(input logic [7:0] a);
		xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] sbox(input logic [7:0] v);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		sbox = t[v];
	endfunction

	function automatic logic [7:0] inv_sbox(input logic [7:0] v);
		logic [7:0] t [256];
		t = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
		inv_sbox = t[v];
	endfunction

endpackage
`default_nettype wire

@@ src/aes_ctrl.sv @@
// aes_ctrl: sequencer for key expansion, whitening and the fourteen rounds
// depends on aes_pkg
`timescale 1ns / 1ps
`default_nettype none
module aes_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	input  wire logic                   key_wr,
	output aes_pkg::dp_cmd_t            cmd,
	input  wire aes_pkg::dp_status_t    status
);
	aes_pkg::state_t state_q, state_nx;
	logic       ready_q;
	logic [3:0] rnd_q;
	logic       acc;

	assign acc = in_valid && !in_stall;

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			aes_pkg::ST_IDLE:   if (acc) state_nx = ready_q ? aes_pkg::ST_PRIME : aes_pkg::ST_EXPAND;
			aes_pkg::ST_EXPAND: if (status.exp_done) state_nx = aes_pkg::ST_PRIME;
			aes_pkg::ST_PRIME:  state_nx = aes_pkg::ST_WHITEN;
			aes_pkg::ST_WHITEN: state_nx = aes_pkg::ST_ROUND;
			aes_pkg::ST_ROUND:  if (rnd_q == 4'(aes_pkg::ROUNDS)) state_nx = aes_pkg::ST_DONE;
			aes_pkg::ST_DONE:   if (!out_stall) state_nx = aes_pkg::ST_IDLE;
			default:            state_nx = aes_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		in_stall = (state_q != aes_pkg::ST_IDLE);
		out_valid = (state_q == aes_pkg::ST_DONE);
		cmd.rnd = rnd_q;
		unique case (state_q)
			aes_pkg::ST_IDLE: begin
				cmd.load = acc;
				cmd.exp_start = acc && !ready_q;
			end
			aes_pkg::ST_EXPAND: cmd.exp_step = 1'b1;
			aes_pkg::ST_PRIME:  cmd.fetch = 1'b1;
			aes_pkg::ST_WHITEN: begin
				cmd.addk = 1'b1;
				cmd.fetch = 1'b1;
			end
			aes_pkg::ST_ROUND: begin
				cmd.round = 1'b1;
				cmd.fetch = 1'b1;
			end
			default: ;
		endcase
	end

	// state, round counter, key-ready flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aes_pkg::ST_IDLE;
			rnd_q   <= '0;
			ready_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == aes_pkg::ST_WHITEN || state_q == aes_pkg::ST_ROUND)
				rnd_q <= rnd_q + 4'd1;
			else
				rnd_q <= '0;
			if (key_wr) ready_q <= 1'b0;
			else if (state_q == aes_pkg::ST_EXPAND && status.exp_done) ready_q <= 1'b1;
		end
	end
endmodule
`default_nettype wire

@@ src/aes_dp.sv @@
// aes_dp: key registers, round-key store, key expansion and round datapath
// depends on aes_pkg and aes_round
`timescale 1ns / 1ps
`default_nettype none
module aes_dp (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 key_wr,
	input  wire logic [1:0]           key_idx,
	input  wire logic [63:0]          key_data,
	input  wire aes_pkg::in_item_t    in_item,
	input  wire aes_pkg::dp_cmd_t     cmd,
	output aes_pkg::dp_status_t       status,
	output aes_pkg::out_item_t        out_item
);
	logic [63:0]      key_q [4];
	// one row of four words per round, column 0 in the top lane
	logic [3:0][31:0] store [aes_pkg::ROUNDS+1];
	logic [127:0]     rk_q;
	logic [127:0]     st;
	logic             dec_q;
	// expansion window of the last eight words
	logic [31:0]  win_q [8];
	logic [5:0]   widx_q;
	logic [2:0]   rc_q;
	logic [7:0]   rcon;
	logic [31:0]  t_w, new_w;
	logic [3:0]   nrnd;
	logic [3:0]   frnd;

	// key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) key_q[i] <= '0;
		end else if (key_wr) begin
			key_q[key_idx] <= key_data;
		end
	end

	always_comb begin
		unique case (rc_q)
			3'd0: rcon = 8'h01;  3'd1: rcon = 8'h02;
			3'd2: rcon = 8'h04;  3'd3: rcon = 8'h08;
			3'd4: rcon = 8'h10;  3'd5: rcon = 8'h20;
			default: rcon = 8'h40;
		endcase
	end

	// next schedule word
	function automatic logic [31:0] subw(input logic [31:0] w);
		subw = {aes_pkg::sbox(w[31:24]), aes_pkg::sbox(w[23:16]),
			aes_pkg::sbox(w[15:8]), aes_pkg::sbox(w[7:0])};
	endfunction

	always_comb begin
		t_w = win_q[7];
		if (widx_q[2:0] == 3'd0) t_w = subw({win_q[7][23:0], win_q[7][31:24]}) ^ {rcon, 24'h0};
		else if (widx_q[2:0] == 3'd4) t_w = subw(win_q[7]);
		new_w = win_q[0] ^ t_w;
	end

	assign status.exp_done = (widx_q == 6'(aes_pkg::SCHED_WORDS));

	// expansion counter and round constant
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			widx_q <= '0;
			rc_q   <= '0;
		end else if (cmd.exp_start) begin
			widx_q <= '0;
			rc_q   <= '0;
		end else if (cmd.exp_step && !status.exp_done) begin
			widx_q <= widx_q + 6'd1;
			if (widx_q >= 6'd8 && widx_q[2:0] == 3'd0) rc_q <= rc_q + 3'd1;
		end
	end

	// window: key words first, then slides by one per derived word
	always_ff @(posedge clk) begin
		if (cmd.exp_start) begin
			for (int i = 0; i < 8; i++)
				win_q[i] <= i[0] ? key_q[i/2][31:0] : key_q[i/2][63:32];
		end else if (cmd.exp_step && !status.exp_done && widx_q >= 6'd8) begin
			for (int i = 0; i < 7; i++) win_q[i] <= win_q[i+1];
			win_q[7] <= new_w;
		end
	end

	// store write: the first eight words straight from the key, then derived words
	always_ff @(posedge clk) begin
		if (cmd.exp_step && !status.exp_done)
			store[widx_q[5:2]][~widx_q[1:0]] <= (widx_q < 6'd8) ? win_q[widx_q[2:0]] : new_w;
	end

	// round-key fetch: one registered row read per cycle while fetch is asserted and the row index is in range
	always_comb begin
		nrnd = (cmd.round || cmd.addk) ? cmd.rnd + 4'd1 : 4'd0;
		frnd = dec_q ? 4'(aes_pkg::ROUNDS) - nrnd : nrnd;
	end
	always_ff @(posedge clk) begin
		if (cmd.fetch && frnd <= 4'(aes_pkg::ROUNDS))
			rk_q <= store[frnd];
	end

	// direction of the block in flight
	always_ff @(posedge clk) begin
		if (cmd.load) dec_q <= in_item.command;
	end

	// round function
	function automatic logic [7:0] gm(input logic [7:0] a, input logic [3:0] m);
		logic [7:0] a2, a4, a8;
		a2 = aes_pkg::xt(a); a4 = aes_pkg::xt(a2); a8 = aes_pkg::xt(a4);
		gm = (m[0] ? a : 8'h0) ^ (m[1] ? a2 : 8'h0) ^ (m[2] ? a4 : 8'h0) ^ (m[3] ? a8 : 8'h0);
	endfunction

	logic [7:0] sb [16];
	logic [7:0] ss [16];
	logic [7:0] ak [16];
	logic [7:0] mx [16];
	logic [127:0] nxt;
	logic last;
	always_comb begin
		last = (cmd.rnd == 4'(aes_pkg::ROUNDS));
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++) begin
				sb[r+4*c] = st[127-8*(r+4*(dec_q ? ((c+4-r)%4) : ((c+r)%4))) -: 8];
				ss[r+4*c] = dec_q ? aes_pkg::inv_sbox(sb[r+4*c]) : aes_pkg::sbox(sb[r+4*c]);
			end
		// encrypt: sub/shift, mix, add key; decrypt: sub/shift, add key, mix; mix is skipped in the last round
		for (int i = 0; i < 16; i++) ak[i] = dec_q ? ss[i] ^ rk_q[127-8*i -: 8] : ss[i];
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				mx[r+4*c] = dec_q ?
					gm(ak[4*c+r], 4'd14) ^ gm(ak[4*c+(r+1)%4], 4'd11) ^
					gm(ak[4*c+(r+2)%4], 4'd13) ^ gm(ak[4*c+(r+3)%4], 4'd9) :
					gm(ak[4*c+r], 4'd2) ^ gm(ak[4*c+(r+1)%4], 4'd3) ^
					ak[4*c+(r+2)%4] ^ ak[4*c+(r+3)%4];
		for (int i = 0; i < 16; i++) begin
			if (dec_q) nxt[127-8*i -: 8] = last ? ak[i] : mx[i];
			else nxt[127-8*i -: 8] = (last ? ss[i] : mx[i]) ^ rk_q[127-8*i -: 8];
		end
	end

	// state register: load, whitening key, then rounds
	aes_round u_round (
		.clk(clk), .load(cmd.load), .blk({in_item.block_upper, in_item.block_lower}),
		.addk(cmd.addk), .rk(rk_q), .upd(cmd.round), .nxt(nxt), .st(st)
	);

	assign out_item = st;
endmodule
`default_nettype wire

@@ src/aes_round.sv @@
// aes_round: state register with initial key addition and round update
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module aes_round (
	input  wire logic         clk,
	input  wire logic         load,
	input  wire logic [127:0] blk,
	input  wire logic         addk,
	input  wire logic [127:0] rk,
	input  wire logic         upd,
	input  wire logic [127:0] nxt,
	output logic [127:0]      st
);
	logic [127:0] st_q;
	// load block, then whitening key, then rounds
	always_ff @(posedge clk) begin
		if (load) st_q <= blk;
		else if (addk) st_q <= st_q ^ rk;
		else if (upd) st_q <= nxt;
	end
	assign st = st_q;
endmodule
`default_nettype wire

@@ src/aes256_block_cipher.sv @@
// aes256_block_cipher: AES-256 ECB block cipher, top level
// sequence: with keys ready, an accepted block passes through key read, whitening,
// 14 rounds and the result beat, preceded by key expansion on the first block after reset
// or a key write; a new block is taken only after the result beat has been accepted,
// one block at a time through the shared round unit
// reset clears key registers, the key-ready flag and the sequencer; the key store is not cleared
`timescale 1ns / 1ps
`default_nettype none
module aes256_block_cipher (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire aes_pkg::in_item_t    in_data,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output aes_pkg::out_item_t        out_data,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [1:0]           cfg_index,
	input  wire logic [63:0]          cfg_data
);
	aes_pkg::dp_cmd_t    cmd;
	aes_pkg::dp_status_t status;
	logic                key_wr;

	assign cfg_ready = 1'b1;
	assign key_wr = cfg_valid && cfg_ready;

	aes_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall),
		.key_wr(key_wr), .cmd(cmd), .status(status)
	);

	aes_dp u_dp (
		.clk(clk), .arst_n(arst_n),
		.key_wr(key_wr), .key_idx(cfg_index), .key_data(cfg_data),
		.in_item(in_data), .cmd(cmd), .status(status), .out_item(out_data)
	);
endmodule
`default_nettype wire
